/* hw/rtl/urm_pkg.sv */
// Shared types and constants for the ultrasonic range meter.
// Used by urm_tick, urm_conv and ultrasonic_range_meter_core; no dependencies.
`default_nettype none

package urm_pkg;

  localparam int COUNTER_BITS_DEF = 32;
  localparam int CFG_W            = 32;
  localparam int TRIG_W           = 16;
  localparam int CFG_IDX_BITS     = 3;
  localparam int DIST_BITS        = 10;
  localparam int INCH_BITS        = 13;

  localparam logic [INCH_BITS-1:0] INCH_FACTOR = 13'd6750;
  localparam logic [DIST_BITS-1:0] DIST_MAX    = 10'd1023;
  localparam logic [DIST_BITS-1:0] DIST_CLEAR  = 10'd1000;

  localparam logic [CFG_W-1:0]  TPS_RST       = 32'd1000000;
  localparam logic [CFG_W-1:0]  MIN_ECHO_RST  = 32'd250;
  localparam logic [CFG_W-1:0]  MAX_ECHO_RST  = 32'd10000;
  localparam logic [CFG_W-1:0]  PERIOD_RST    = 32'd100000;
  localparam logic [TRIG_W-1:0] TRIGGER_RST   = 16'd10;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TPS,
    REG_MIN_ECHO,
    REG_MAX_ECHO,
    REG_PERIOD,
    REG_TRIGGER
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0]  ticks_per_second;
    logic [CFG_W-1:0]  min_echo_ticks;
    logic [CFG_W-1:0]  max_echo_ticks;
    logic [CFG_W-1:0]  period_ticks;
    logic [TRIG_W-1:0] trigger_ticks;
  } urm_cfg_t;

  // per-tick outcome from the tick logic
  typedef struct packed {
    logic trig;
    logic done;
    logic launch;
  } tick_res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_MUL,
    CV_DIV,
    CV_DONE
  } conv_state_t;

endpackage

`default_nettype wire

/* hw/rtl/urm_tick.sv */
// Per-tick state of the range meter: trigger period counter, echo width
// counter, echo window check and running min/max. Depends on urm_pkg.
`default_nettype none

module urm_tick #(
  parameter int COUNTER_BITS = urm_pkg::COUNTER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic                            echo_level,
  input  logic                            enable,
  input  urm_pkg::urm_cfg_t               cfg,
  input  logic                            conv_done,
  input  logic [urm_pkg::DIST_BITS-1:0]   conv_dist,
  output urm_pkg::tick_res_t              res,
  output logic [COUNTER_BITS-1:0]         count,
  output logic [urm_pkg::DIST_BITS-1:0]   min_next,
  output logic [urm_pkg::DIST_BITS-1:0]   max_next
);
  import urm_pkg::*;

  localparam int CMPW = (COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W;

  logic                    prev_echo;
  logic [COUNTER_BITS-1:0] echo_count;
  logic [CFG_W-1:0]        period_count;
  logic                    prev_enable;
  logic [DIST_BITS-1:0]    min_dist;
  logic [DIST_BITS-1:0]    max_dist;

  logic [CFG_W:0]  pc_inc;
  logic            pc_wrap;
  logic            count_full;
  logic            fall;
  logic            in_win;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] min_ext;
  logic [CMPW-1:0] max_ext;

  assign pc_inc     = {1'b0, period_count} + {{CFG_W{1'b0}}, 1'b1};
  assign pc_wrap    = pc_inc >= {1'b0, cfg.period_ticks};
  assign count_full = &echo_count;
  assign cnt_ext    = CMPW'(echo_count);
  assign min_ext    = CMPW'(cfg.min_echo_ticks);
  assign max_ext    = CMPW'(cfg.max_echo_ticks);
  assign in_win     = (cnt_ext >= min_ext) && (cnt_ext <= max_ext);
  assign fall       = enable && !echo_level && prev_echo;

  always_comb begin
    res.trig   = enable && (period_count < {{(CFG_W-TRIG_W){1'b0}}, cfg.trigger_ticks});
    res.done   = fall;
    res.launch = fall && in_win;
  end

  assign count = echo_count;

  always_comb begin
    min_next = min_dist;
    max_next = max_dist;
    if (accept && !enable && prev_enable) begin
      min_next = DIST_CLEAR;
      max_next = '0;
    end else if (conv_done) begin
      if (conv_dist < min_dist) min_next = conv_dist;
      if (conv_dist > max_dist) max_next = conv_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_echo    <= 1'b0;
      echo_count   <= '0;
      period_count <= '0;
      prev_enable  <= 1'b0;
      min_dist     <= DIST_CLEAR;
      max_dist     <= '0;
    end else begin
      min_dist <= min_next;
      max_dist <= max_next;
      if (accept) begin
        prev_enable <= enable;
        if (enable) begin
          period_count <= pc_wrap ? '0 : pc_inc[CFG_W-1:0];
          if (echo_level) begin
            if (!count_full) echo_count <= echo_count + {{(COUNTER_BITS-1){1'b0}}, 1'b1};
          end else if (prev_echo) begin
            echo_count <= '0;
          end
          prev_echo <= echo_level;
        end else begin
          period_count <= '0;
          echo_count   <= '0;
          prev_echo    <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/urm_conv.sv */
// Bit-serial distance conversion: count * 6750 by a serial-parallel
// multiplier, then restoring division by the tick rate, one bit per cycle.
// Depends on urm_pkg.
`default_nettype none

module urm_conv #(
  parameter int COUNTER_BITS = urm_pkg::COUNTER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [COUNTER_BITS-1:0]       count,
  input  logic [urm_pkg::CFG_W-1:0]     tps,
  output urm_pkg::conv_stat_t           stat,
  output logic [urm_pkg::DIST_BITS-1:0] inches
);
  import urm_pkg::*;

  localparam int PW        = COUNTER_BITS + INCH_BITS;
  localparam int STEP_BITS = $clog2(PW);
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(PW - 1);

  conv_state_t state, state_next;

  logic [COUNTER_BITS-1:0] work;
  logic [INCH_BITS-1:0]    acc;
  logic [PW-1:0]           prod;
  logic [CFG_W-1:0]        rem;
  logic [DIST_BITS-1:0]    quo;
  logic                    sat;
  logic [STEP_BITS-1:0]    step;

  logic [INCH_BITS:0] mul_sum;
  logic [CFG_W:0]     trial;
  logic [CFG_W:0]     trial_sub;
  logic               qbit;
  logic               last;

  assign mul_sum   = {1'b0, acc} + (work[0] ? {1'b0, INCH_FACTOR} : '0);
  assign trial     = {rem, prod[PW-1]};
  assign trial_sub = trial - {1'b0, tps};
  assign qbit      = trial >= {1'b0, tps};
  assign last      = step == LAST_STEP;

  always_comb begin
    state_next = state;
    case (state)
      CV_IDLE: if (start) state_next = CV_MUL;
      CV_MUL:  if (last) state_next = CV_DIV;
      CV_DIV:  if (last) state_next = CV_DONE;
      CV_DONE: state_next = CV_IDLE;
      default: state_next = CV_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = 1'b0;
    stat.done = 1'b0;
    case (state)
      CV_IDLE: stat.busy = 1'b0;
      CV_MUL,
      CV_DIV:  stat.busy = 1'b1;
      CV_DONE: begin
        stat.busy = 1'b1;
        stat.done = 1'b1;
      end
      default: stat.busy = 1'b0;
    endcase
  end

  assign inches = sat ? DIST_MAX : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CV_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == CV_IDLE || last) step <= '0;
      else                          step <= step + {{(STEP_BITS-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      CV_IDLE: begin
        work <= count;
        acc  <= '0;
        rem  <= '0;
        quo  <= '0;
        sat  <= 1'b0;
      end
      CV_MUL: begin
        // product leaves LSB first and fills prod from the top
        work <= work >> 1;
        acc  <= mul_sum[INCH_BITS:1];
        prod <= {mul_sum[0], prod[PW-1:1]};
      end
      CV_DIV: begin
        rem  <= qbit ? trial_sub[CFG_W-1:0] : trial[CFG_W-1:0];
        prod <= prod << 1;
        quo  <= {quo[DIST_BITS-2:0], qbit};
        sat  <= sat | quo[DIST_BITS-1];
      end
      default: begin
        work <= work;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/ultrasonic_range_meter_core.sv */
// Ultrasonic echo ranging meter: tick channel in, one result per tick out.
// Input channel (in_valid/in_stall) carries one time tick: echo_level, enable.
// Output channel (out_valid/out_stall) returns one result for every tick:
// trigger_level, measure_done, in_range, distance_inches, min_seen, max_seen.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high, unknown indexes are dropped. Write only while idle.
// Flow: an ordinary tick is loaded into the output register at its
// transfer, and ticks flow at one per cycle while neither the converter is
// busy nor the receiver stalls. A tick that ends an echo inside the width
// window runs the bit-serial converter through its multiply, divide and
// finish states (CV_MUL, CV_DIV, CV_DONE) before its result is loaded;
// in_stall is high while the converter is busy.
// When the receiver stalls, the result holds in the output register and
// in_stall stays high until it is taken.
// Reset (rst, synchronous) restores the default registers, clears counters,
// sets the running min/max to 1000 and 0, and empties the output register.
// Depends on urm_pkg, urm_tick, urm_conv.
`default_nettype none

module ultrasonic_range_meter_core #(
  parameter int COUNTER_BITS = urm_pkg::COUNTER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             echo_level,
  input  logic                             enable,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             trigger_level,
  output logic                             measure_done,
  output logic                             in_range,
  output logic [urm_pkg::DIST_BITS-1:0]    distance_inches,
  output logic [urm_pkg::DIST_BITS-1:0]    min_seen,
  output logic [urm_pkg::DIST_BITS-1:0]    max_seen,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [urm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [urm_pkg::CFG_W-1:0]        cfg_data
);
  import urm_pkg::*;

  urm_cfg_t   cfg;
  tick_res_t  tick;
  conv_stat_t conv_stat;

  logic [COUNTER_BITS-1:0] count;
  logic [DIST_BITS-1:0]    conv_dist;
  logic [DIST_BITS-1:0]    min_next;
  logic [DIST_BITS-1:0]    max_next;
  logic                    accept;
  logic                    load_tick;
  logic                    out_valid_next;
  logic                    trig_hold;

  assign cfg_ready = 1'b1;
  assign in_stall  = conv_stat.busy || (out_valid && out_stall);
  assign accept    = in_valid && !in_stall;
  assign load_tick = accept && !tick.launch;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_second <= TPS_RST;
      cfg.min_echo_ticks   <= MIN_ECHO_RST;
      cfg.max_echo_ticks   <= MAX_ECHO_RST;
      cfg.period_ticks     <= PERIOD_RST;
      cfg.trigger_ticks    <= TRIGGER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TPS:      cfg.ticks_per_second <= cfg_data;
        REG_MIN_ECHO: cfg.min_echo_ticks   <= cfg_data;
        REG_MAX_ECHO: cfg.max_echo_ticks   <= cfg_data;
        REG_PERIOD:   cfg.period_ticks     <= cfg_data;
        REG_TRIGGER:  cfg.trigger_ticks    <= cfg_data[TRIG_W-1:0];
        default:      cfg.trigger_ticks    <= cfg.trigger_ticks;
      endcase
    end
  end

  urm_tick #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_tick (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .echo_level (echo_level),
    .enable     (enable),
    .cfg        (cfg),
    .conv_done  (conv_stat.done),
    .conv_dist  (conv_dist),
    .res        (tick),
    .count      (count),
    .min_next   (min_next),
    .max_next   (max_next)
  );

  urm_conv #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && tick.launch),
    .count  (count),
    .tps    (cfg.ticks_per_second),
    .stat   (conv_stat),
    .inches (conv_dist)
  );

  always_comb begin
    if (load_tick || conv_stat.done) out_valid_next = 1'b1;
    else if (out_stall)              out_valid_next = out_valid;
    else                             out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= out_valid_next;
  end

  always_ff @(posedge clk) begin
    if (accept && tick.launch) trig_hold <= tick.trig;
    if (load_tick) begin
      trigger_level   <= tick.trig;
      measure_done    <= tick.done;
      in_range        <= 1'b0;
      distance_inches <= '0;
      min_seen        <= min_next;
      max_seen        <= max_next;
    end else if (conv_stat.done) begin
      trigger_level   <= trig_hold;
      measure_done    <= 1'b1;
      in_range        <= 1'b1;
      distance_inches <= conv_dist;
      min_seen        <= min_next;
      max_seen        <= max_next;
    end
  end

`ifndef SYNTHESIS
  a_conv_slot_free: assert property (@(posedge clk) disable iff (rst)
    conv_stat.done |-> !out_valid)
    else $error("conversion finished with output register occupied");

  a_launch_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && tick.launch) |=> conv_stat.busy)
    else $error("converter not busy after launch");

  a_conv_result: assert property (@(posedge clk) disable iff (rst)
    conv_stat.done |=> (out_valid && measure_done && in_range))
    else $error("conversion result not presented");
`endif

endmodule

`default_nettype wire

/* sim/ultrasonic_range_meter_core_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ultrasonic_range_meter_core: streams echo ticks,
// predicts each tick's result in step with the block and checks every result field.
// Depends on urm_pkg and the core RTL.

module ultrasonic_range_meter_core_test;
  import urm_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_NONE = 3'd7;
  localparam int CONV_CYCLES = 2 * (COUNTER_BITS_DEF + INCH_BITS) + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                 trig;
    logic                 done;
    logic                 ok;
    logic [DIST_BITS-1:0] inches;
    logic [DIST_BITS-1:0] nearest;
    logic [DIST_BITS-1:0] farthest;
  } range_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    echo_level = 1'b0;
  logic                    enable = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    trigger_level;
  logic                    measure_done;
  logic                    in_range;
  logic [DIST_BITS-1:0]    distance_inches;
  logic [DIST_BITS-1:0]    min_seen;
  logic [DIST_BITS-1:0]    max_seen;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;

  ultrasonic_range_meter_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .echo_level(echo_level), .enable(enable),
    .out_valid(out_valid), .out_stall(out_stall),
    .trigger_level(trigger_level), .measure_done(measure_done),
    .in_range(in_range), .distance_inches(distance_inches),
    .min_seen(min_seen), .max_seen(max_seen),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted block state
  logic [CFG_W-1:0]            tps_q, min_echo_q, max_echo_q, period_q;
  logic [TRIG_W-1:0]           trigger_q;
  logic                        echo_was_high, enable_was_high;
  logic [COUNTER_BITS_DEF-1:0] pulse_ticks;
  logic [CFG_W-1:0]            phase_ticks;
  logic [DIST_BITS-1:0]        nearest, farthest;

  range_result_t range_pending[$];
  int            mismatches = 0;
  int            ticks_sent = 0;
  int            send_idle_pct = 18;
  int            recv_stall_pct = 46;
  int            quiet_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic reset_predictor();
    tps_q = TPS_RST;
    min_echo_q = MIN_ECHO_RST;
    max_echo_q = MAX_ECHO_RST;
    period_q = PERIOD_RST;
    trigger_q = TRIGGER_RST;
    echo_was_high = 1'b0;
    enable_was_high = 1'b0;
    pulse_ticks = '0;
    phase_ticks = '0;
    nearest = DIST_CLEAR;
    farthest = '0;
  endtask

  function automatic logic [DIST_BITS-1:0] inches_for(input logic [63:0] ticks);
    logic [63:0] q, r, d;
    if (tps_q == '0) return DIST_MAX;
    q = ticks / tps_q;
    r = ticks % tps_q;
    if (q > DIST_MAX) return DIST_MAX;
    d = q * INCH_FACTOR + (r * INCH_FACTOR) / tps_q;
    return (d > DIST_MAX) ? DIST_MAX : d[DIST_BITS-1:0];
  endfunction

  function automatic range_result_t predict_tick(input logic echo, input logic en);
    range_result_t r;
    r = '0;
    if (en) begin
      r.trig = (phase_ticks < trigger_q);
      if ({1'b0, phase_ticks} + 33'd1 >= {1'b0, period_q}) phase_ticks = '0;
      else phase_ticks = phase_ticks + 1'b1;
      if (echo) begin
        if (pulse_ticks != '1) pulse_ticks = pulse_ticks + 1'b1;
      end else if (echo_was_high) begin
        r.done = 1'b1;
        if (pulse_ticks >= min_echo_q && pulse_ticks <= max_echo_q) begin
          r.ok = 1'b1;
          r.inches = inches_for(64'(pulse_ticks));
          if (r.inches < nearest) nearest = r.inches;
          if (r.inches > farthest) farthest = r.inches;
        end
        pulse_ticks = '0;
      end
      echo_was_high = echo;
    end else begin
      if (enable_was_high) begin
        nearest = DIST_CLEAR;
        farthest = '0;
      end
      phase_ticks = '0;
      pulse_ticks = '0;
      echo_was_high = 1'b0;
    end
    enable_was_high = en;
    r.nearest = nearest;
    r.farthest = farthest;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DIST_BITS-1:0] want,
                             input logic [DIST_BITS-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    range_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (range_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("%0t: result with none pending", $time);
      end else begin
        want = range_pending.pop_front();
        check_field("trigger_level", 10'(want.trig), 10'(trigger_level));
        check_field("measure_done", 10'(want.done), 10'(measure_done));
        check_field("in_range", 10'(want.ok), 10'(in_range));
        check_field("distance_inches", want.inches, distance_inches);
        check_field("min_seen", want.nearest, min_seen);
        check_field("max_seen", want.farthest, max_seen);
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("ultrasonic_range_meter_core_test: errors");
      $finish;
    end
  end

  task automatic send_tick(input logic echo, input logic en);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    echo_level <= echo;
    enable <= en;
    do @(posedge clk); while (in_stall);
    range_pending.push_back(predict_tick(echo, en));
    ticks_sent++;
  endtask

  task automatic send_echo(input int width, input int gap);
    repeat (width) send_tick(1'b1, 1'b1);
    repeat (gap) send_tick(1'b0, 1'b1);
  endtask

  // wait for the block to go idle: all results in, converter finished
  task automatic drain();
    in_valid <= 1'b0;
    while (range_pending.size() != 0) @(posedge clk);
    repeat (CONV_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TPS:      tps_q = data;
      REG_MIN_ECHO: min_echo_q = data;
      REG_MAX_ECHO: max_echo_q = data;
      REG_PERIOD:   period_q = data;
      REG_TRIGGER:  trigger_q = data[TRIG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setup(input logic [CFG_W-1:0] tps, input logic [CFG_W-1:0] lo_w,
                            input logic [CFG_W-1:0] hi_w, input logic [CFG_W-1:0] period,
                            input logic [TRIG_W-1:0] trig);
    drain();
    write_reg(REG_TPS, tps);
    write_reg(REG_MIN_ECHO, lo_w);
    write_reg(REG_MAX_ECHO, hi_w);
    write_reg(REG_PERIOD, period);
    write_reg(REG_TRIGGER, CFG_W'(trig));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    repeat (3) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_trigger_timing();
    load_setup(32'd50, 32'd3, 32'd5, 32'd3, 16'd2);
    send_tick(1'b0, 1'b0);
    repeat (4) send_tick(1'b0, 1'b1);
  endtask

  task automatic test_trigger_corners();
    load_setup(32'd50, 32'd3, 32'd5, 32'd3, 16'd0);
    repeat (2) send_tick(1'b0, 1'b1);
    load_setup(32'd50, 32'd3, 32'd5, 32'd0, 16'hFFFF);
    repeat (2) send_tick(1'b0, 1'b1);
  endtask

  task automatic test_echo_window();
    load_setup(32'd50, 32'd3, 32'd5, 32'hFFFF_FFFF, 16'd1);
    send_echo(2, 1);
    send_echo(3, 1);
    send_echo(6, 1);
  endtask

  task automatic test_enable_edges();
    load_setup(32'd50, 32'd1, 32'hFFFF_FFFF, 32'd5, 16'd1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
  endtask

  task automatic test_divisor_corners();
    load_setup(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd7, 16'd1);
    send_echo(1, 1);
    load_setup(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd7, 16'd1);
    send_echo(1, 1);
    load_setup(32'd1, 32'd0, 32'hFFFF_FFFF, 32'd7, 16'd1);
    send_echo(1, 1);
  endtask

  task automatic test_unused_index();
    drain();
    write_reg(REG_NONE, 32'd0);
    cfg_valid <= 1'b0;
    send_echo(2, 1);
  endtask

  task automatic random_setup();
    logic [CFG_W-1:0]  tps, lo_w, hi_w, period;
    logic [TRIG_W-1:0] trig;
    case ($urandom_range(5))
      0: tps = 32'hFFFF_FFFF;
      1: tps = 32'd0;
      2: tps = 32'd1;
      default: tps = $urandom_range(20, 400);
    endcase
    lo_w = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 8);
    if (lo_w == 32'hFFFF_FFFF || $urandom_range(7) == 0) hi_w = 32'hFFFF_FFFF;
    else hi_w = lo_w + $urandom_range(0, 12);
    case ($urandom_range(5))
      0: period = 32'd0;
      1: period = 32'hFFFF_FFFF;
      default: period = $urandom_range(1, 40);
    endcase
    case ($urandom_range(5))
      0: trig = 16'd0;
      1: trig = 16'hFFFF;
      default: trig = TRIG_W'($urandom_range(1, 20));
    endcase
    load_setup(tps, lo_w, hi_w, period, trig);
  endtask

  // mostly clean echo pulses, with enable dropouts, drained pauses and fresh random setups mixed in
  task automatic test_random_ranging(input int count, input int idle_pct, input int stall_pct);
    int stop_at, next_setup, roll;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = ticks_sent + count;
    next_setup = ticks_sent;
    while (ticks_sent < stop_at) begin
      if (ticks_sent >= next_setup) begin
        random_setup();
        next_setup = ticks_sent + 110;
      end
      roll = $urandom_range(99);
      if (roll < 6) begin
        repeat ($urandom_range(1, 3)) send_tick(1'($urandom_range(1)), 1'b0);
      end else if (roll < 9) begin
        drain();
      end else begin
        send_echo($urandom_range(1, 24), $urandom_range(1, 4));
      end
    end
  endtask

  initial begin
    reset_predictor();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_trigger_timing();
    test_trigger_corners();
    test_echo_window();
    test_enable_edges();
    test_divisor_corners();
    test_unused_index();
    test_random_ranging(333, 18, 46);
    test_random_ranging(333, 46, 18);
    test_random_ranging(334, 0, 0);
    drain();
    if (mismatches == 0 && range_pending.size() == 0) begin
      $display("ultrasonic_range_meter_core_test: clean");
    end else begin
      $display("ultrasonic_range_meter_core_test: errors");
    end
    $finish;
  end

endmodule
